/* hw/rtl/pptb_pkg.sv */
// Shared types, register codes and constants for the parallel port tape bridge.
package pptb_pkg;

   localparam int BUFFER_DEPTH = 131072;
   localparam int PTR_W        = 17;
   localparam int MOD_STEPS    = 7;

   localparam logic [1:0] CMD_DATA   = 2'd0;
   localparam logic [1:0] CMD_CTRL   = 2'd1;
   localparam logic [1:0] CMD_STATUS = 2'd2;

   localparam logic [7:0] REG_INTR    = 8'h00;
   localparam logic [7:0] REG_PROTO   = 8'h04;
   localparam logic [7:0] REG_IRQ_CMD = 8'h06;
   localparam logic [7:0] REG_CRC_CTL = 8'h0b;
   localparam logic [7:0] REG_IRQ_EN  = 8'h0f;
   localparam logic [7:0] REG_TEST    = 8'h13;
   localparam logic [7:0] REG_CRC     = 8'h22;
   localparam logic [7:0] REG_DEFER   = 8'h24;
   localparam logic [7:0] REG_PTR     = 8'h28;
   localparam logic [7:0] REG_BUF     = 8'ha0;

   localparam logic [15:0] CRC_POLY     = 16'h1021;
   localparam logic [15:0] CRC_SEED     = 16'hffff;
   localparam logic [7:0]  DEFER_KEY    = 8'ha4;
   localparam logic [7:0]  STATUS_MASK  = 8'hf8;
   localparam logic [7:0]  PROTO_FIELD  = 8'h18;
   localparam logic [7:0]  CRC_CLR_KEY  = 8'h0b;
   localparam logic [7:0]  IRQ_TEST_KEY = 8'h80;
   localparam logic [7:0]  FORCE_KEY    = 8'h09;
   localparam logic [7:0]  KNOCK_KEY    = 8'h04;
   localparam logic [7:0]  REPLY_EPP    = 8'hc0;
   localparam logic [7:0]  REPLY_SPP    = 8'h40;
   localparam logic [7:0]  INTR_BASE    = 8'h10;

   typedef struct packed {
      logic       we;
      logic [7:0] addr;
      logic [7:0] data;
   } rf_wr_type;

endpackage

/* hw/rtl/pptb_regfile.sv */
// 256-byte register file memory with per-entry valid bits cleared at reset.
module pptb_regfile (
   input  logic              clock,
   input  logic              reset,
   input  pptb_pkg::rf_wr_type wr,
   input  logic              rd_en,
   input  logic [7:0]        rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [256];
   logic [255:0] valid_ff;
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.we) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/pptb_buffer.sv */
// Transfer buffer memory, one write and one registered read port.
module pptb_buffer #(
   parameter int BUFFER_DEPTH = pptb_pkg::BUFFER_DEPTH,
   localparam int AW = $clog2(BUFFER_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/parallel_port_tape_bridge_unit.sv */
// Host parallel-port access bridge: link control, register file and buffer.
// Each item passes through a read stage that reads the register file and the
// buffer at the addressed register and the buffer pointer, then an update stage
// that updates the state and writes both memories back. A new item is taken only
// while the read stage is empty and the update stage is empty or passing its item
// on; the output register lets the next item enter while a result waits. No
// clearing pass is needed after reset.
module parallel_port_tape_bridge_unit #(
   parameter int BUFFER_DEPTH = pptb_pkg::BUFFER_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_status,
   output logic       rsp_irq_line,
   output logic [7:0] rsp_data_echo,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_max_protocol
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int MW = pptb_pkg::PTR_W + pptb_pkg::MOD_STEPS;

   function automatic logic [15:0] crc_feed(input logic [15:0] c0, input logic [7:0] b);
      logic [15:0] c;
      c = c0 ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ pptb_pkg::CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [1:0] decode_bits(input logic [7:0] b);
      logic [7:0] f;
      f = b & pptb_pkg::PROTO_FIELD;
      case (f[4:3])
         2'b10:   return 2'd1;
         2'b11:   return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [7:0] spread(input logic [3:0] n);
      return {n[3], 1'b0, n[2:0], 3'b000};
   endfunction

   function automatic logic [AW-1:0] buf_mod(input logic [pptb_pkg::PTR_W-1:0] p);
      logic [MW-1:0] r;
      logic [MW-1:0] d;
      r = MW'(p);
      for (int k = pptb_pkg::MOD_STEPS - 1; k >= 0; k--) begin
         d = MW'(BUFFER_DEPTH) << k;
         if (r >= d) begin
            r = r - d;
         end
      end
      return r[AW-1:0];
   endfunction

   // pipeline
   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic [1:0] s1_cmd_ff, s2_cmd_ff;
   logic [7:0] s1_val_ff, s2_val_ff;
   logic [AW-1:0] s2_bidx_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_status_ff, rsp_data_ff;
   logic       rsp_irq_ff;
   logic       out_free, exec, accept;

   // link state
   logic [7:0] ctrl_ff, ctrl_in, data_ff, data_in;
   logic       link_ff, link_in;
   logic [1:0] proto_ff, proto_in;
   logic       karm_ff, karm_in;
   logic [1:0] kedges_ff, kedges_in, reply_ff, reply_in;
   logic       force_ff, force_in;
   logic [7:0] areg_ff, areg_in;
   logic [1:0] run_ff, run_in;
   logic [7:0] rbyte_ff, rbyte_in;
   logic       hinib_ff, hinib_in;
   logic [7:0] nstat_ff, nstat_in, tcnt_ff, tcnt_in;
   logic [1:0] irqen_ff, irqen_in;
   logic       irqpend_ff, irqpend_in, irqtest_ff, irqtest_in, irqlvl_ff, irqlvl_in;
   logic [7:0] defbits_ff, defbits_in;
   logic       defok_ff, defok_in;
   logic [15:0] crc_ff, crc_in;
   logic [pptb_pkg::PTR_W-1:0] ptr_ff, ptr_in;
   logic       warm_ff, warm_in, burst_ff, burst_in;
   logic [2:0] maxp_ff;
   logic [7:0] status_calc;

   pptb_pkg::rf_wr_type rf_wr;
   logic [7:0] rf_rd, buf_rd, buf_wd;
   logic       buf_we;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exec      = s2_valid_ff && out_free;
   assign req_ready = !s1_valid_ff && (!s2_valid_ff || exec);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = accept;
   assign s2_valid_in  = s1_valid_ff || (s2_valid_ff && !exec);
   assign rsp_valid_in = exec || (rsp_valid_ff && !rsp_ready);

   pptb_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr      (rf_wr),
      .rd_en   (s1_valid_ff),
      .rd_addr (areg_ff),
      .rd_data (rf_rd)
   );

   pptb_buffer #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (s2_bidx_ff),
      .wr_data (buf_wd),
      .rd_en   (s1_valid_ff),
      .rd_addr (buf_mod(ptr_ff)),
      .rd_data (buf_rd)
   );

   always_comb begin
      logic [1:0] cmd;
      logic [7:0] v;
      logic [7:0] chg;
      logic [7:0] rr;
      logic [1:0] idx;
      logic [AW-1:0] nidx;
      logic active;
      ctrl_in = ctrl_ff;    data_in = data_ff;     link_in = link_ff;
      proto_in = proto_ff;  karm_in = karm_ff;     kedges_in = kedges_ff;
      reply_in = reply_ff;  force_in = force_ff;   areg_in = areg_ff;
      run_in = run_ff;      rbyte_in = rbyte_ff;   hinib_in = hinib_ff;
      nstat_in = nstat_ff;  tcnt_in = tcnt_ff;     irqen_in = irqen_ff;
      irqpend_in = irqpend_ff; irqtest_in = irqtest_ff; irqlvl_in = irqlvl_ff;
      defbits_in = defbits_ff; defok_in = defok_ff; crc_in = crc_ff;
      ptr_in = ptr_ff;      warm_in = warm_ff;     burst_in = burst_ff;
      rf_wr = '{we: 1'b0, addr: areg_ff, data: data_ff};
      buf_we = 1'b0;
      buf_wd = data_ff;
      status_calc = 8'h00;
      cmd = s2_cmd_ff;
      v = s2_val_ff;
      chg = ctrl_ff ^ v;
      rr = 8'h00;
      idx = run_ff;
      active = link_ff && areg_ff == pptb_pkg::REG_BUF && warm_ff && ctrl_ff[0];
      nidx = (s2_bidx_ff == AW'(BUFFER_DEPTH - 1)) ? '0 : s2_bidx_ff + 1'b1;

      if (cmd == pptb_pkg::CMD_DATA) begin
         data_in = v;
         if (!active) begin
            burst_in = 1'b0;
         end else if (!burst_ff) begin
            burst_in = 1'b1;
         end else if (v != data_ff) begin
            buf_we = 1'b1;
            buf_wd = v;
            ptr_in = pptb_pkg::PTR_W'(nidx);
            crc_in = crc_feed(crc_ff, v);
         end
      end else if (cmd == pptb_pkg::CMD_CTRL) begin
         ctrl_in = v;
         if (chg != 8'h00) begin
            if (force_ff) begin
               if (chg[1]) begin
                  proto_in = decode_bits(data_ff);
                  force_in = 1'b0;
               end else if (v == 8'h00 && link_ff) begin
                  link_in = 1'b0; karm_in = 1'b0; kedges_in = 2'd0; reply_in = 2'd0;
                  force_in = 1'b0; nstat_in = 8'h00;
                  irqlvl_in = irqpend_ff && irqen_ff == 2'd3;
               end
            end else if (link_ff && v == pptb_pkg::FORCE_KEY) begin
               force_in = 1'b1;
            end else if (!link_ff && v == pptb_pkg::KNOCK_KEY && kedges_ff == 2'd0) begin
               karm_in = 1'b1;
            end else if (chg[3]) begin
               if (link_ff) begin
                  if (v[3]) begin
                     link_in = 1'b0; karm_in = 1'b0; kedges_in = 2'd0; reply_in = 2'd0;
                     force_in = 1'b0; nstat_in = 8'h00;
                     irqlvl_in = irqpend_ff && irqen_ff == 2'd3;
                  end
               end else if (karm_ff) begin
                  if (kedges_ff >= 2'd2) begin
                     link_in = 1'b1; karm_in = 1'b0; kedges_in = 2'd0;
                     hinib_in = 1'b0; nstat_in = 8'h00;
                     if (defok_ff) begin
                        proto_in = decode_bits(defbits_ff);
                        defok_in = 1'b0;
                     end
                     irqlvl_in = 1'b0;
                     reply_in = 2'd2;
                  end else begin
                     kedges_in = kedges_ff + 2'd1;
                  end
               end
            end else if (link_ff) begin
               if (reply_ff != 2'd0) begin
                  if (chg[1]) begin
                     reply_in = reply_ff - 2'd1;
                  end
               end else begin
                  if (chg[0] && !v[0]) begin
                     burst_in = 1'b0;
                  end
                  if (chg[1]) begin
                     areg_in = data_ff;
                     run_in = 2'd0;
                     hinib_in = 1'b0;
                     burst_in = 1'b0;
                  end else if (chg[2]) begin
                     if (v[0]) begin
                        run_in = (run_ff < 2'd3) ? run_ff + 2'd1 : run_ff;
                        rf_wr.we = 1'b1;
                        case (areg_ff)
                           pptb_pkg::REG_PROTO: begin
                              proto_in = decode_bits(data_ff);
                              warm_in = data_ff[7];
                              if (irqtest_ff) begin
                                 irqpend_in = 1'b1;
                                 irqlvl_in = 1'b1;
                              end
                           end
                           pptb_pkg::REG_IRQ_CMD: begin
                              irqtest_in = data_ff == pptb_pkg::IRQ_TEST_KEY;
                              if (data_ff == 8'h00) begin
                                 irqpend_in = 1'b0;
                                 irqlvl_in = 1'b0;
                              end
                           end
                           pptb_pkg::REG_CRC_CTL: begin
                              if (data_ff == pptb_pkg::CRC_CLR_KEY) begin
                                 crc_in = pptb_pkg::CRC_SEED;
                              end
                           end
                           pptb_pkg::REG_IRQ_EN: begin
                              irqen_in = data_ff[4:3];
                              irqlvl_in = irqpend_ff && !link_ff && data_ff[4:3] == 2'd3;
                           end
                           pptb_pkg::REG_TEST: begin
                              tcnt_in = data_ff;
                           end
                           pptb_pkg::REG_DEFER: begin
                              if (idx == 2'd0) begin
                                 defbits_in = data_ff;
                                 defok_in = 1'b0;
                              end else if (idx == 2'd1 && data_ff == pptb_pkg::DEFER_KEY) begin
                                 defok_in = 1'b1;
                              end
                           end
                           pptb_pkg::REG_PTR: begin
                              case (idx)
                                 2'd0:    ptr_in[7:0] = data_ff;
                                 2'd1:    ptr_in[15:8] = data_ff;
                                 2'd2:    ptr_in[16] = data_ff[0];
                                 default: ptr_in = ptr_ff;
                              endcase
                           end
                           pptb_pkg::REG_BUF: begin
                              buf_we = 1'b1;
                              buf_wd = data_ff;
                              ptr_in = pptb_pkg::PTR_W'(nidx);
                              crc_in = crc_feed(crc_ff, data_ff);
                           end
                           default: begin
                              rf_wr.we = 1'b1;
                           end
                        endcase
                     end else if (proto_ff != 2'd0 || {1'b0, proto_ff} > maxp_ff) begin
                        nstat_in = spread(4'hf);
                        hinib_in = !hinib_ff;
                     end else if (hinib_ff) begin
                        nstat_in = spread(rbyte_ff[7:4]);
                        hinib_in = 1'b0;
                     end else begin
                        run_in = (run_ff < 2'd3) ? run_ff + 2'd1 : run_ff;
                        case (areg_ff)
                           pptb_pkg::REG_INTR: begin
                              rr = pptb_pkg::INTR_BASE | {7'd0, irqpend_ff && irqen_ff[1]};
                           end
                           pptb_pkg::REG_IRQ_EN: begin
                              rr = {3'd0, irqen_ff, 2'd0, irqpend_ff};
                           end
                           pptb_pkg::REG_TEST: begin
                              rr = tcnt_ff;
                              tcnt_in = tcnt_ff + 8'd1;
                           end
                           pptb_pkg::REG_CRC: begin
                              rr = (idx == 2'd0) ? crc_ff[7:0] : crc_ff[15:8];
                           end
                           pptb_pkg::REG_BUF: begin
                              rr = buf_rd;
                              ptr_in = pptb_pkg::PTR_W'(nidx);
                              crc_in = crc_feed(crc_ff, buf_rd);
                           end
                           default: begin
                              rr = rf_rd;
                           end
                        endcase
                        rbyte_in = rr;
                        nstat_in = spread(rr[3:0]);
                        hinib_in = 1'b1;
                     end
                  end
               end
            end
         end
      end else if (cmd == pptb_pkg::CMD_STATUS) begin
         if (reply_ff != 2'd0) begin
            status_calc = (proto_ff >= 2'd2) ? pptb_pkg::REPLY_EPP : pptb_pkg::REPLY_SPP;
         end else if (link_ff) begin
            status_calc = nstat_ff;
         end
         status_calc = status_calc & pptb_pkg::STATUS_MASK;
      end
      rf_wr.we = rf_wr.we && exec;
      buf_we = buf_we && exec;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= req_command;
         s1_val_ff <= req_value;
      end
      if (s1_valid_ff) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_val_ff <= s1_val_ff;
         s2_bidx_ff <= buf_mod(ptr_ff);
      end
      if (exec) begin
         rsp_status_ff <= status_calc;
         rsp_irq_ff <= irqlvl_in;
         rsp_data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;  s2_valid_ff <= 1'b0;  rsp_valid_ff <= 1'b0;
         maxp_ff <= 3'd0;
         ctrl_ff <= 8'h00;     data_ff <= 8'h00;     link_ff <= 1'b0;
         proto_ff <= 2'd0;     karm_ff <= 1'b0;      kedges_ff <= 2'd0;
         reply_ff <= 2'd0;     force_ff <= 1'b0;     areg_ff <= 8'h00;
         run_ff <= 2'd0;       rbyte_ff <= 8'h00;    hinib_ff <= 1'b0;
         nstat_ff <= 8'h00;    tcnt_ff <= 8'h00;     irqen_ff <= 2'd0;
         irqpend_ff <= 1'b0;   irqtest_ff <= 1'b0;   irqlvl_ff <= 1'b0;
         defbits_ff <= 8'h00;  defok_ff <= 1'b0;     crc_ff <= pptb_pkg::CRC_SEED;
         ptr_ff <= '0;         warm_ff <= 1'b0;      burst_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            maxp_ff <= csr_max_protocol;
         end
         if (exec) begin
            ctrl_ff <= ctrl_in;     data_ff <= data_in;       link_ff <= link_in;
            proto_ff <= proto_in;   karm_ff <= karm_in;       kedges_ff <= kedges_in;
            reply_ff <= reply_in;   force_ff <= force_in;     areg_ff <= areg_in;
            run_ff <= run_in;       rbyte_ff <= rbyte_in;     hinib_ff <= hinib_in;
            nstat_ff <= nstat_in;   tcnt_ff <= tcnt_in;       irqen_ff <= irqen_in;
            irqpend_ff <= irqpend_in; irqtest_ff <= irqtest_in; irqlvl_ff <= irqlvl_in;
            defbits_ff <= defbits_in; defok_ff <= defok_in;   crc_ff <= crc_in;
            ptr_ff <= ptr_in;       warm_ff <= warm_in;       burst_ff <= burst_in;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_irq_line  = rsp_irq_ff;
   assign rsp_data_echo = rsp_data_ff;

   a_stage_excl: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s2_valid_ff))
      else $error("read and update stages both hold an item");

   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item not in read stage");

   a_reply_range: assert property (@(posedge clock) disable iff (reset)
      reply_ff != 2'd3)
      else $error("connect reply count out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff))
      else $error("result raised without an item in the update stage");

endmodule

/* tb/tb_parallel_port_tape_bridge_unit.sv */
// Self-checking testbench for the parallel port tape bridge: directed table, random link traffic.
module tb_parallel_port_tape_bridge_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_NONE     = 2'd3;
   localparam logic [7:0] REG_DMA_ADDR = 8'h2c;
   localparam logic [7:0] REG_DMA_LEN  = 8'h30;
   localparam logic [7:0] REG_ECC      = 8'h34;
   localparam int         STALL_LIMIT  = 4000;

   typedef struct packed {
      logic [7:0] status;
      logic       irq;
      logic [7:0] echo;
   } access_result_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] v;
      bit         typed;
      logic [7:0] s;
      logic       i;
      logic [7:0] e;
   } script_row_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_command = '0;
   logic [7:0] req_value = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_status;
   logic       rsp_irq_line;
   logic [7:0] rsp_data_echo;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [2:0] csr_max_protocol = '0;

   parallel_port_tape_bridge_unit DUT (.*);

   // bridge state as the host sees it
   logic [7:0]  port_ctl, port_data, mode_bits, cur_reg, rd_byte, nib_stat, test_cnt;
   logic [7:0]  defer_bits;
   logic [2:0]  proto, proto_cap;
   logic [1:0]  knock_cnt, reply_left, run_idx, irq_en;
   logic        linked, knock_primed, force_wait, hi_nib, irq_pend, irq_test, irq_out;
   logic        defer_ok, wr_armed, burst_on;
   logic [15:0] crc;
   logic [16:0] buf_ptr;
   logic [23:0] dma_base, dma_len;
   logic [7:0]  regs [256];
   logic [7:0]  ecc [2];
   logic [7:0]  tape_buf [int];

   access_result_type pending_results [$];
   access_result_type want;
   int  mismatches = 0;
   int  sent = 0;
   int  stall = 0;
   bit  calm = 0, steady = 0, hold_req = 0, held = 0;

   function automatic logic [2:0] proto_of(logic [7:0] b);
      case (b & pptb_pkg::PROTO_FIELD)
         8'h10:   return 3'd1;
         8'h18:   return 3'd2;
         default: return 3'd0;
      endcase
   endfunction

   function automatic void crc_feed(logic [7:0] v);
      logic [15:0] c;
      c = crc ^ {v, 8'h00};
      for (int b = 0; b < 8; b++) c = c[15] ? ((c << 1) ^ pptb_pkg::CRC_POLY) : (c << 1);
      crc = c;
   endfunction

   function automatic logic [7:0] buf_read();
      logic [7:0] v;
      v = tape_buf.exists(int'(buf_ptr)) ? tape_buf[int'(buf_ptr)] : 8'h00;
      buf_ptr = buf_ptr + 1'b1;
      crc_feed(v);
      return v;
   endfunction

   function automatic void buf_write(logic [7:0] v);
      tape_buf[int'(buf_ptr)] = v;
      buf_ptr = buf_ptr + 1'b1;
      crc_feed(v);
   endfunction

   function automatic void irq_upd(bit poke);
      irq_out = irq_pend && (poke || (!linked && irq_en == 2'd3));
   endfunction

   function automatic logic [1:0] next_idx();
      logic [1:0] idx;
      idx = run_idx;
      if (run_idx < 2'd3) run_idx++;
      return idx;
   endfunction

   function automatic logic [7:0] reg_read(logic [7:0] r);
      logic [1:0] idx;
      logic [7:0] v;
      idx = next_idx();
      case (r)
         pptb_pkg::REG_INTR:   v = pptb_pkg::INTR_BASE | {7'b0, irq_pend && irq_en[1]};
         pptb_pkg::REG_IRQ_EN: v = {3'b000, irq_en, 2'b00, irq_pend};
         pptb_pkg::REG_TEST: begin
            v = test_cnt;
            test_cnt++;
         end
         pptb_pkg::REG_CRC:    v = (idx == 2'd0) ? crc[7:0] : crc[15:8];
         pptb_pkg::REG_BUF:    v = buf_read();
         default:              v = regs[r];
      endcase
      return v;
   endfunction

   function automatic void reg_write(logic [7:0] r, logic [7:0] v);
      logic [1:0]  idx;
      logic [23:0] wide;
      idx = next_idx();
      regs[r] = v;
      case (r)
         pptb_pkg::REG_PROTO: begin
            mode_bits = v;
            proto = proto_of(v);
            wr_armed = v[7];
            if (irq_test) begin
               irq_pend = 1'b1;
               irq_upd(1'b1);
            end
         end
         pptb_pkg::REG_IRQ_CMD: begin
            irq_test = (v == pptb_pkg::IRQ_TEST_KEY);
            if (v == 8'h00) begin
               irq_pend = 1'b0;
               irq_upd(1'b0);
            end
         end
         pptb_pkg::REG_CRC_CTL: if (v == pptb_pkg::CRC_CLR_KEY) crc = pptb_pkg::CRC_SEED;
         pptb_pkg::REG_IRQ_EN: begin
            irq_en = v[4:3];
            irq_upd(1'b0);
         end
         pptb_pkg::REG_TEST: test_cnt = v;
         pptb_pkg::REG_DEFER: begin
            if (idx == 2'd0) begin
               defer_bits = v;
               defer_ok = 1'b0;
            end else if (idx == 2'd1 && v == pptb_pkg::DEFER_KEY) begin
               defer_ok = 1'b1;
            end
         end
         pptb_pkg::REG_PTR: if (idx <= 2'd2) begin
            wide = {7'b0, buf_ptr};
            wide[idx*8 +: 8] = v;
            buf_ptr = wide[16:0];
         end
         REG_DMA_ADDR: if (idx <= 2'd2) dma_base[idx*8 +: 8] = v;
         REG_DMA_LEN:  if (idx <= 2'd2) dma_len[idx*8 +: 8] = v;
         REG_ECC:      if (idx < 2'd2) ecc[idx] = v;
         pptb_pkg::REG_BUF: buf_write(v);
         default: ;
      endcase
   endfunction

   function automatic void link_up_now();
      linked = 1'b1;
      knock_primed = 1'b0;
      knock_cnt = 2'd0;
      hi_nib = 1'b0;
      nib_stat = 8'h00;
      if (defer_ok) begin
         mode_bits = defer_bits;
         proto = proto_of(defer_bits);
         defer_ok = 1'b0;
      end
      irq_upd(1'b0);
      reply_left = 2'd2;
   endfunction

   function automatic void link_down();
      if (!linked) return;
      linked = 1'b0;
      knock_primed = 1'b0;
      knock_cnt = 2'd0;
      reply_left = 2'd0;
      force_wait = 1'b0;
      nib_stat = 8'h00;
      irq_upd(1'b0);
   endfunction

   function automatic logic [7:0] spread(logic [3:0] n);
      return {n[3], 1'b0, n[2:0], 3'b000};
   endfunction

   function automatic void nib_read();
      if (proto != 3'd0 || proto > proto_cap) begin
         nib_stat = spread(4'hf);
         hi_nib = !hi_nib;
      end else if (hi_nib) begin
         nib_stat = spread(rd_byte[7:4]);
         hi_nib = 1'b0;
      end else begin
         rd_byte = reg_read(cur_reg);
         nib_stat = spread(rd_byte[3:0]);
         hi_nib = 1'b1;
      end
   endfunction

   function automatic void data_write(logic [7:0] v);
      logic [7:0] old;
      bit         active;
      old = port_data;
      active = linked && cur_reg == pptb_pkg::REG_BUF && wr_armed && port_ctl[0];
      port_data = v;
      if (!active) burst_on = 1'b0;
      else if (!burst_on) burst_on = 1'b1;
      else if (v != old) buf_write(v);
   endfunction

   function automatic void ctrl_write(logic [7:0] v);
      logic [7:0] chg;
      chg = port_ctl ^ v;
      port_ctl = v;
      if (chg == 8'h00) return;
      if (force_wait) begin
         if (chg[1]) begin
            mode_bits = port_data;
            proto = proto_of(port_data);
            force_wait = 1'b0;
         end else if (v == 8'h00) begin
            link_down();
         end
         return;
      end
      if (linked && v == pptb_pkg::FORCE_KEY) begin
         force_wait = 1'b1;
         return;
      end
      if (!linked && v == pptb_pkg::KNOCK_KEY && knock_cnt == 2'd0) begin
         knock_primed = 1'b1;
         return;
      end
      if (chg[3]) begin
         if (linked) begin
            if (v[3]) link_down();
         end else if (knock_primed) begin
            knock_cnt++;
            if (knock_cnt >= 2'd3) link_up_now();
         end
         return;
      end
      if (!linked) return;
      if (reply_left > 2'd0) begin
         if (chg[1]) reply_left--;
         return;
      end
      if (chg[0] && !v[0]) burst_on = 1'b0;
      if (chg[1]) begin
         cur_reg = port_data;
         run_idx = 2'd0;
         hi_nib = 1'b0;
         burst_on = 1'b0;
         return;
      end
      if (chg[2]) begin
         if (v[0]) reg_write(cur_reg, port_data);
         else nib_read();
      end
   endfunction

   function automatic logic [7:0] status_read();
      logic [7:0] s;
      if (reply_left > 2'd0) s = (proto >= 3'd2) ? pptb_pkg::REPLY_EPP : pptb_pkg::REPLY_SPP;
      else if (linked) s = nib_stat;
      else s = 8'h00;
      return s & pptb_pkg::STATUS_MASK;
   endfunction

   function automatic access_result_type predict(logic [1:0] cmd, logic [7:0] v);
      logic [7:0] st;
      st = 8'h00;
      case (cmd)
         pptb_pkg::CMD_DATA:   data_write(v);
         pptb_pkg::CMD_CTRL:   ctrl_write(v);
         pptb_pkg::CMD_STATUS: st = status_read();
         default: ;
      endcase
      return '{st, irq_out, port_data};
   endfunction

   // true when this control write would fetch a buffer entry never written
   function automatic bit would_read_unwritten(logic [1:0] cmd, logic [7:0] v);
      logic [7:0] chg;
      chg = port_ctl ^ v;
      if (cmd != pptb_pkg::CMD_CTRL || chg == 8'h00 || force_wait) return 0;
      if (linked && v == pptb_pkg::FORCE_KEY) return 0;
      if (!linked || chg[3] || reply_left != 2'd0 || chg[1] || !chg[2] || v[0]) return 0;
      if (proto != 3'd0 || hi_nib || cur_reg != pptb_pkg::REG_BUF) return 0;
      return !tape_buf.exists(int'(buf_ptr));
   endfunction

   function automatic void model_reset();
      port_ctl = '0; port_data = '0; linked = 1'b0; proto = '0; mode_bits = 8'h24;
      knock_primed = 1'b0; knock_cnt = '0; reply_left = '0; force_wait = 1'b0;
      cur_reg = '0; run_idx = '0; rd_byte = '0; hi_nib = 1'b0; nib_stat = '0;
      foreach (regs[k]) regs[k] = 8'h00;
      test_cnt = '0; irq_en = '0; irq_pend = 1'b0; irq_test = 1'b0; irq_out = 1'b0;
      defer_bits = '0; defer_ok = 1'b0; crc = pptb_pkg::CRC_SEED; buf_ptr = '0;
      tape_buf.delete();
      wr_armed = 1'b0; burst_on = 1'b0; dma_base = '0; dma_len = '0;
      ecc[0] = '0; ecc[1] = '0; proto_cap = '0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send(input logic [1:0] cmd, input logic [7:0] v, input bit typed = 0,
                       input logic [7:0] s = 8'h00, input logic i = 1'b0,
                       input logic [7:0] e = 8'h00);
      access_result_type r;
      if (would_read_unwritten(cmd, v)) v[0] = 1'b1;
      r = predict(cmd, v);
      if (typed) r = '{s, i, e};
      pending_results.push_back(r);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (!calm && !steady && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic write_proto_cap(input logic [2:0] v);
      csr_valid <= 1'b1;
      csr_max_protocol <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      proto_cap = v;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // toggle control bits, steering clear of the force key by accident
   task automatic flip(input logic [7:0] mask);
      logic [7:0] v;
      v = port_ctl ^ mask;
      if (v == pptb_pkg::FORCE_KEY) v ^= 8'h40;
      send(pptb_pkg::CMD_CTRL, v);
   endtask

   task automatic select_reg(input logic [7:0] r);
      send(pptb_pkg::CMD_DATA, r);
      flip(8'h02);
   endtask

   task automatic put_reg(input logic [7:0] v);
      if (!port_ctl[0]) flip(8'h01);
      send(pptb_pkg::CMD_DATA, v);
      flip(8'h04);
   endtask

   task automatic get_reg();
      if (port_ctl[0]) flip(8'h01);
      flip(8'h04);
      send(pptb_pkg::CMD_STATUS, 8'($urandom_range(0, 255)));
      flip(8'h04);
      send(pptb_pkg::CMD_STATUS, 8'($urandom_range(0, 255)));
   endtask

   task automatic set_pointer(input logic [16:0] p);
      select_reg(pptb_pkg::REG_PTR);
      put_reg(p[7:0]);
      put_reg(p[15:8]);
      put_reg({7'b0, p[16]});
   endtask

   task automatic connect();
      if (knock_cnt == 2'd0) begin
         if (port_ctl == pptb_pkg::KNOCK_KEY) send(pptb_pkg::CMD_CTRL, 8'h00);
         send(pptb_pkg::CMD_CTRL, pptb_pkg::KNOCK_KEY);
      end
      repeat (4) if (!linked) flip(8'h08);
   endtask

   function automatic logic [7:0] pick_reg();
      logic [7:0] codes [15] = '{pptb_pkg::REG_INTR, pptb_pkg::REG_PROTO,
                                 pptb_pkg::REG_IRQ_CMD, pptb_pkg::REG_CRC_CTL,
                                 pptb_pkg::REG_IRQ_EN, pptb_pkg::REG_TEST, pptb_pkg::REG_CRC,
                                 pptb_pkg::REG_DEFER, pptb_pkg::REG_PTR, REG_DMA_ADDR,
                                 REG_DMA_LEN, REG_ECC, pptb_pkg::REG_BUF, 8'hff, 8'h00};
      int k;
      k = $urandom_range(0, 15);
      return (k == 15) ? 8'($urandom_range(0, 255)) : codes[k];
   endfunction

   task automatic traffic(input int goal);
      int          op, k;
      logic [16:0] p;
      logic [7:0]  b;
      while (sent < goal) begin
         steady = ($urandom_range(0, 3) == 0);
         op = $urandom_range(0, 12);
         if (op == 0) begin
            repeat ($urandom_range(1, 4))
               send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end else if (!linked) begin
            connect();
         end else if (reply_left != 2'd0 || force_wait) begin
            send(pptb_pkg::CMD_STATUS, 8'($urandom_range(0, 255)));
            flip(8'h02);
         end else begin
            case (op)
               1: begin
                  if (port_ctl[3]) flip(8'h08);
                  flip(8'h08);
               end
               2: begin
                  select_reg(pick_reg());
                  repeat ($urandom_range(1, 4)) put_reg(8'($urandom_range(0, 255)));
               end
               3: begin
                  select_reg(pick_reg());
                  repeat ($urandom_range(1, 4)) get_reg();
               end
               4, 5: begin
                  p = {1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))};
                  if ($urandom_range(0, 3) == 0) p = 17'h1ffff - 17'($urandom_range(0, 3));
                  k = $urandom_range(1, 8);
                  set_pointer(p);
                  select_reg(pptb_pkg::REG_BUF);
                  repeat (k) put_reg(8'($urandom_range(0, 255)));
                  set_pointer(p);
                  select_reg(pptb_pkg::REG_BUF);
                  repeat (k) get_reg();
                  select_reg(pptb_pkg::REG_CRC);
                  get_reg();
                  get_reg();
               end
               6: begin
                  select_reg(pptb_pkg::REG_PROTO);
                  put_reg(8'h80 | ($urandom_range(0, 7) == 0 ? 8'h18 : 8'h00));
                  select_reg(pptb_pkg::REG_BUF);
                  if (!port_ctl[0]) flip(8'h01);
                  repeat ($urandom_range(2, 12))
                     send(pptb_pkg::CMD_DATA,
                          8'($urandom_range(0, 3)) * 8'($urandom_range(1, 85)));
               end
               7: begin
                  select_reg(pptb_pkg::REG_IRQ_CMD);
                  put_reg(pptb_pkg::IRQ_TEST_KEY);
                  select_reg(pptb_pkg::REG_PROTO);
                  put_reg(8'($urandom_range(0, 255)) & 8'h67);
                  select_reg(pptb_pkg::REG_IRQ_EN);
                  put_reg(8'($urandom_range(0, 3)) << 3);
                  select_reg(pptb_pkg::REG_INTR);
                  get_reg();
                  select_reg(pptb_pkg::REG_IRQ_EN);
                  get_reg();
                  if ($urandom_range(0, 1)) begin
                     if (port_ctl[3]) flip(8'h08);
                     flip(8'h08);
                  end
               end
               8: begin
                  select_reg(pptb_pkg::REG_DEFER);
                  b = 8'($urandom_range(0, 255));
                  put_reg(b);
                  put_reg($urandom_range(0, 3) == 0 ? b : pptb_pkg::DEFER_KEY);
                  if (port_ctl[3]) flip(8'h08);
                  flip(8'h08);
               end
               9: begin
                  if (port_ctl != pptb_pkg::FORCE_KEY)
                     send(pptb_pkg::CMD_CTRL, pptb_pkg::FORCE_KEY);
                  send(pptb_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
                  if ($urandom_range(0, 2) != 0) flip(8'h02);
                  else send(pptb_pkg::CMD_CTRL, 8'h00);
               end
               10: begin
                  select_reg(pptb_pkg::REG_PROTO);
                  put_reg(8'($urandom_range(0, 255)) & 8'he7);
                  select_reg(pick_reg());
                  get_reg();
               end
               11: begin
                  select_reg(pptb_pkg::REG_CRC_CTL);
                  put_reg(pptb_pkg::CRC_CLR_KEY);
                  select_reg(pptb_pkg::REG_IRQ_CMD);
                  put_reg(8'h00);
                  select_reg(pptb_pkg::REG_TEST);
                  put_reg(8'($urandom_range(250, 255)));
                  repeat ($urandom_range(1, 8)) get_reg();
               end
               default: begin
                  select_reg(REG_ECC);
                  repeat ($urandom_range(1, 4)) put_reg(8'($urandom_range(0, 255)));
               end
            endcase
         end
      end
   endtask

   // receiver: random holds, one long hold-off for back-pressure
   initial begin
      forever begin
         if (hold_req && !held) begin
            held = 1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && !steady && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing expected: status %h irq %b echo %h",
                   rsp_status, rsp_irq_line, rsp_data_echo);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %h, actual %h", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_irq_line !== want.irq) begin
               $error("irq_line: expected %b, actual %b", want.irq, rsp_irq_line);
               mismatches++;
            end
            if (rsp_data_echo !== want.echo) begin
               $error("data_echo: expected %h, actual %h", want.echo, rsp_data_echo);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall <= 0;
      else
         stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   script_row_type script [25] = '{
      '{pptb_pkg::CMD_STATUS, 8'h00, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_DATA,   8'hff, 1, 8'h00, 1'b0, 8'hff},
      '{pptb_pkg::CMD_DATA,   8'h00, 1, 8'h00, 1'b0, 8'h00},
      '{CMD_NONE,             8'haa, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_CTRL,   8'hff, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_CTRL,   8'h00, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_CTRL,   8'h04, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_CTRL,   8'h0c, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_CTRL,   8'h04, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_CTRL,   8'h0c, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_STATUS, 8'hff, 1, 8'h40, 1'b0, 8'h00},
      '{pptb_pkg::CMD_CTRL,   8'h0e, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_STATUS, 8'h00, 1, 8'h40, 1'b0, 8'h00},
      '{pptb_pkg::CMD_CTRL,   8'h0c, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_STATUS, 8'h00, 1, 8'h00, 1'b0, 8'h00},
      '{pptb_pkg::CMD_DATA,   8'ha0, 1, 8'h00, 1'b0, 8'ha0},
      '{pptb_pkg::CMD_CTRL,   8'h0e, 1, 8'h00, 1'b0, 8'ha0},
      '{pptb_pkg::CMD_CTRL,   8'h0f, 1, 8'h00, 1'b0, 8'ha0},
      '{pptb_pkg::CMD_DATA,   8'h5a, 1, 8'h00, 1'b0, 8'h5a},
      '{pptb_pkg::CMD_CTRL,   8'h0b, 1, 8'h00, 1'b0, 8'h5a},
      '{pptb_pkg::CMD_CTRL,   8'h0f, 1, 8'h00, 1'b0, 8'h5a},
      '{pptb_pkg::CMD_CTRL,   8'h09, 1, 8'h00, 1'b0, 8'h5a},
      '{pptb_pkg::CMD_DATA,   8'h18, 1, 8'h00, 1'b0, 8'h18},
      '{pptb_pkg::CMD_CTRL,   8'h0b, 1, 8'h00, 1'b0, 8'h18},
      '{pptb_pkg::CMD_STATUS, 8'h00, 0, 8'h00, 1'b0, 8'h00}
   };

   initial begin
      model_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_proto_cap(3'd0);
      foreach (script[k]) send(script[k].cmd, script[k].v, script[k].typed,
                               script[k].s, script[k].i, script[k].e);
      traffic(420);
      req_valid <= 1'b0;
      drain();
      write_proto_cap(3'd4);
      hold_req = 1;
      traffic(820);
      req_valid <= 1'b0;
      drain();
      write_proto_cap(3'($urandom_range(1, 3)));
      traffic(1220);
      req_valid <= 1'b0;
      drain();
      write_proto_cap(3'd0);
      calm = 1;
      traffic(1550);
      req_valid <= 1'b0;
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
